FILE: design/assert_macros.svh
// Assertion macros shared by the crop, mirror and normalise unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset
`define ICMN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included
`define ICMN_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICMN_ASSERT(lbl, prop, msg)
`define ICMN_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: design/icmn_pkg.sv
// Shared widths, register indexes and structs of the crop, mirror and normalise unit.
// No dependencies; imported by the interfaces and the modules.
package icmn_pkg;

    localparam int PIXEL_W      = 8;
    localparam int VALUE_W      = 33;
    localparam int INDEX_W      = 22;
    localparam int DIM_CFG_W    = 11;
    localparam int CHAN_CFG_W   = 3;
    localparam int ORIGIN_W     = 20;
    localparam int OFFSET_W     = 10;
    localparam int SCALE_W      = 24;
    localparam int MEAN_W       = 16;
    localparam int MEAN_LANES   = 4;
    localparam int DIFF_W       = 17;
    localparam int PROD_W       = DIFF_W + SCALE_W + 1;
    localparam int FRAC_DROP    = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 4;

    localparam int DEFAULT_MAX_DIM      = 1024;
    localparam int DEFAULT_MAX_CHANNELS = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    // Register indexes on the configuration channel
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 4'd0,
        REG_IMAGE_HEIGHT  = 4'd1,
        REG_CHANNEL_COUNT = 4'd2,
        REG_CROP_SIDE     = 4'd3,
        REG_CROP_ORIGIN   = 4'd4,
        REG_MIRROR_ENABLE = 4'd5,
        REG_SCALE_FACTOR  = 4'd6,
        REG_CHANNEL_MEANS = 4'd7
    } cfg_index_t;

    // Raw configuration registers as written by software
    typedef struct packed {
        logic [DIM_CFG_W-1:0]                image_width;
        logic [DIM_CFG_W-1:0]                image_height;
        logic [CHAN_CFG_W-1:0]               channel_count;
        logic [DIM_CFG_W-1:0]                crop_side;
        logic [ORIGIN_W-1:0]                 crop_origin;
        logic                                mirror_enable;
        logic [SCALE_W-1:0]                  scale_factor;
        logic [MEAN_LANES-1:0][MEAN_W-1:0]   channel_means;
    } cfg_regs_t;

    // Kept pixel on its way from the position stage to the scaling stage
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [INDEX_W-1:0]       dest_index;
        logic                     last_of_image;
    } stage_t;

endpackage

FILE: design/icmn_if.sv
// Channel interfaces of the crop, mirror and normalise unit: pixels, results, register writes.
// Depends on icmn_pkg for the payload widths.
interface icmn_pixel_if
    import icmn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               first_of_image;

    modport source (output valid, output pixel, output first_of_image, input ready);
    modport sink   (input valid, input pixel, input first_of_image, output ready);
endinterface

interface icmn_result_if
    import icmn_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        dest_index;
    logic                      last_of_image;

    modport source (output valid, output value, output dest_index, output last_of_image,
                    input ready);
    modport sink   (input valid, input value, input dest_index, input last_of_image,
                    output ready);
endinterface

interface icmn_cfg_if
    import icmn_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/icmn_cfg_regs.sv
// Configuration register file of the crop, mirror and normalise unit.
// Depends on icmn_pkg and the icmn_cfg_if interface.
module icmn_cfg_regs
    import icmn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    icmn_cfg_if.sink         cfg,
    output cfg_regs_t        regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // Always take a write transfer
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_IMAGE_WIDTH:   regs_next.image_width   = cfg.data[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT:  regs_next.image_height  = cfg.data[DIM_CFG_W-1:0];
                REG_CHANNEL_COUNT: regs_next.channel_count = cfg.data[CHAN_CFG_W-1:0];
                REG_CROP_SIDE:     regs_next.crop_side     = cfg.data[DIM_CFG_W-1:0];
                REG_CROP_ORIGIN:   regs_next.crop_origin   = cfg.data[ORIGIN_W-1:0];
                REG_MIRROR_ENABLE: regs_next.mirror_enable = cfg.data[0];
                REG_SCALE_FACTOR:  regs_next.scale_factor  = cfg.data[SCALE_W-1:0];
                REG_CHANNEL_MEANS: regs_next.channel_means = cfg.data;
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.image_width   <= DIM_CFG_W'(1);
            regs_reg.image_height  <= DIM_CFG_W'(1);
            regs_reg.channel_count <= CHAN_CFG_W'(1);
            regs_reg.crop_side     <= '0;
            regs_reg.crop_origin   <= '0;
            regs_reg.mirror_enable <= 1'b0;
            regs_reg.scale_factor  <= SCALE_RESET;
            regs_reg.channel_means <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: design/icmn_position.sv
// Position stage: channel/row/column counters, crop window test, mirrored index,
// last flag and mean subtraction, held in the stage register.
// Depends on icmn_pkg, icmn_pixel_if and assert_macros.svh.
`include "assert_macros.svh"
module icmn_position
    import icmn_pkg::*;
#(
    parameter int MAX_DIM      = DEFAULT_MAX_DIM,
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
)
(
    input  logic         clk,
    input  logic         rst_n,
    icmn_pixel_if.sink   pixels,
    input  cfg_regs_t    regs,
    output logic         stage_valid,
    input  logic         stage_ready,
    output stage_t       stage
);

    localparam int DW  = $clog2(MAX_DIM);
    localparam int EW  = $clog2(MAX_DIM + 1);
    localparam int XW  = (EW > DIM_CFG_W) ? EW : DIM_CFG_W;
    localparam int OW  = (EW > OFFSET_W) ? EW : OFFSET_W;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNW = $clog2(MAX_CHANNELS + 1);
    localparam int SELW = $clog2(MEAN_LANES);

    logic [CHW-1:0]     chan_pos_reg, chan_pos_next;
    logic [DW-1:0]      row_pos_reg, row_pos_next;
    logic [DW-1:0]      col_pos_reg, col_pos_next;
    logic [INDEX_W-1:0] out_pos_reg, out_pos_next;
    logic               stage_valid_reg, stage_valid_next;
    stage_t             stage_reg, stage_next;

    logic [XW-1:0]      width_x, height_x, side_x;
    logic [EW-1:0]      w_eff, h_eff, side_min, sw, sh;
    logic [CNW-1:0]     c_eff;
    logic [OW-1:0]      row_field, col_field, row_lim, col_lim;
    logic [EW-1:0]      roff, coff;
    logic               crop_on;

    logic [CHW-1:0]     chan;
    logic [DW-1:0]      row, col;
    logic [INDEX_W-1:0] out_base;
    logic [EW-1:0]      row_e, col_e, rrel, wrel;
    logic               keep, last, accept;
    logic               col_wrap, row_wrap, chan_wrap, image_end;
    logic [INDEX_W-1:0] idx;
    logic [SELW-1:0]    mean_sel;
    logic [MEAN_W-1:0]  mean;
    logic signed [DIFF_W-1:0] diff;

    // Effective image geometry from the raw registers
    always_comb
    begin
        width_x  = XW'(regs.image_width);
        height_x = XW'(regs.image_height);
        side_x   = XW'(regs.crop_side);

        if (width_x == '0)
            w_eff = EW'(1);
        else if (width_x > XW'(MAX_DIM))
            w_eff = EW'(MAX_DIM);
        else
            w_eff = EW'(width_x);

        if (height_x == '0)
            h_eff = EW'(1);
        else if (height_x > XW'(MAX_DIM))
            h_eff = EW'(MAX_DIM);
        else
            h_eff = EW'(height_x);

        if (regs.channel_count == '0)
            c_eff = CNW'(1);
        else if (regs.channel_count > CHAN_CFG_W'(MAX_CHANNELS))
            c_eff = CNW'(MAX_CHANNELS);
        else
            c_eff = CNW'(regs.channel_count);

        crop_on  = (regs.crop_side != '0);
        side_min = (side_x > XW'(w_eff)) ? w_eff : EW'(side_x);
        if (side_min > h_eff)
            side_min = h_eff;
        sw = crop_on ? side_min : w_eff;
        sh = crop_on ? side_min : h_eff;

        // Keep the window inside the image
        row_field = OW'(regs.crop_origin[2*OFFSET_W-1:OFFSET_W]);
        col_field = OW'(regs.crop_origin[OFFSET_W-1:0]);
        row_lim   = OW'(h_eff - side_min);
        col_lim   = OW'(w_eff - side_min);
        roff      = crop_on ? EW'((row_field > row_lim) ? row_lim : row_field) : '0;
        coff      = crop_on ? EW'((col_field > col_lim) ? col_lim : col_field) : '0;
    end

    // Position of this pixel, restarted by a first-of-image mark
    always_comb
    begin
        chan     = pixels.first_of_image ? '0 : chan_pos_reg;
        row      = pixels.first_of_image ? '0 : row_pos_reg;
        col      = pixels.first_of_image ? '0 : col_pos_reg;
        out_base = pixels.first_of_image ? '0 : out_pos_reg;

        row_e = EW'(row);
        col_e = EW'(col);
        rrel  = row_e - roff;
        wrel  = col_e - coff;

        keep = (CNW'(chan) < c_eff) && (row_e >= roff) && (rrel < sh)
               && (col_e >= coff) && (wrel < sw);
        last = (CNW'(chan) == c_eff - CNW'(1)) && (rrel == sh - EW'(1))
               && (wrel == sw - EW'(1));

        // Mirror: out_pos - wrel + (sw - 1 - wrel), modulo the index width
        if (regs.mirror_enable)
            idx = out_base + INDEX_W'(sw) - INDEX_W'(1) - (INDEX_W'(wrel) << 1);
        else
            idx = out_base;

        mean_sel = SELW'(chan);
        mean     = regs.channel_means[mean_sel];
        diff     = $signed({1'b0, pixels.pixel, 8'b0}) - $signed({1'b0, mean});
    end

    // Advance the counters, wrapping at the end of row, plane and image
    always_comb
    begin
        col_wrap  = (col_e + EW'(1)) >= w_eff;
        row_wrap  = (row_e + EW'(1)) >= h_eff;
        chan_wrap = (CNW'(chan) + CNW'(1)) >= c_eff;
        image_end = col_wrap && row_wrap && chan_wrap;

        col_pos_next  = col_wrap ? '0 : DW'(col_e + EW'(1));
        row_pos_next  = row;
        chan_pos_next = chan;
        if (col_wrap)
        begin
            row_pos_next = row_wrap ? '0 : DW'(row_e + EW'(1));
            if (row_wrap)
                chan_pos_next = chan_wrap ? '0 : CHW'(CNW'(chan) + CNW'(1));
        end

        out_pos_next = image_end ? '0 : (out_base + INDEX_W'(keep));
    end

    // Stage register: take a transfer when empty or draining
    assign pixels.ready = !stage_valid_reg || stage_ready;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (accept)
        begin
            stage_valid_next         = keep;
            stage_next.diff          = diff;
            stage_next.dest_index    = idx;
            stage_next.last_of_image = last;
        end
        else if (stage_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_pos_reg    <= '0;
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            out_pos_reg     <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                chan_pos_reg <= chan_pos_next;
                row_pos_reg  <= row_pos_next;
                col_pos_reg  <= col_pos_next;
                out_pos_reg  <= out_pos_next;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

    `ICMN_ASSERT(a_stage_hold, stage_valid_reg && !stage_ready |=> stage_valid_reg && $stable(stage_reg), "stalled stage item changed")
    `ICMN_ASSERT(a_first_restart, accept && pixels.first_of_image && !image_end |=> out_pos_reg == INDEX_W'($past(keep)), "first-of-image did not restart the output count")

endmodule

FILE: design/icmn_scale.sv
// Scaling stage: multiplies the mean-subtracted pixel by the Q8.16 scale and
// holds the result in the output register. Depends on icmn_pkg, icmn_result_if
// and assert_macros.svh.
`include "assert_macros.svh"
module icmn_scale
    import icmn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 stage_valid,
    output logic                 stage_ready,
    input  stage_t               stage,
    input  logic [SCALE_W-1:0]   scale_factor,
    icmn_result_if.source        results
);

    logic                      res_valid_reg, res_valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [INDEX_W-1:0]        index_reg;
    logic                      last_reg;
    logic signed [PROD_W-1:0]  prod;
    logic                      take;

    // Product fits in PROD_W-1 bits; dropping 8 fraction bits floors it
    assign prod       = PROD_W'(stage.diff) * $signed({1'b0, scale_factor});
    assign value_next = prod[VALUE_W+FRAC_DROP-1:FRAC_DROP];

    // Output register: take a transfer when empty or being read
    assign stage_ready = !res_valid_reg || results.ready;
    assign take        = stage_valid && stage_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (take)
            res_valid_next = 1'b1;
        else if (results.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            value_reg <= value_next;
            index_reg <= stage.dest_index;
            last_reg  <= stage.last_of_image;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.value         = value_reg;
    assign results.dest_index    = index_reg;
    assign results.last_of_image = last_reg;

    `ICMN_ASSERT(a_stage_lands, stage_valid && stage_ready |=> res_valid_reg, "stage transfer did not reach the output register")
    `ICMN_ASSERT_RST(a_reset_empty, !rst_n |-> !res_valid_reg, "output valid during reset")

endmodule

FILE: design/image_crop_mirror_normalize_unit.sv
// Top level of the crop, mirror and normalise unit: register file, position stage,
// scaling stage. Depends on icmn_pkg, icmn_if and the icmn_* modules.
//
//  port     | dir  | payload                                  | transfer when
//  ---------+------+------------------------------------------+-----------------
//  pixels   | sink | pixel[7:0], first_of_image               | valid && ready
//  results  | src  | value[32:0] signed, dest_index[21:0],    | valid && ready
//           |      | last_of_image                            |
//  cfg      | sink | index[3:0], data[63:0]                   | valid (ready = 1)
//
// One pixel per cycle while results are read. Registers: the position stage register
// (counters, crop test, index, mean subtraction) and the output register after the
// 17 x 25 bit scaling multiply. Pixels outside the crop window are dropped at the
// position stage. A stalled output holds the result; each stage refills as it drains.
// Reset clears counters, valid flags and registers to their defaults; no clearing pass.
module image_crop_mirror_normalize_unit
    import icmn_pkg::*;
#(
    parameter int MAX_DIM      = DEFAULT_MAX_DIM,
    parameter int MAX_CHANNELS = DEFAULT_MAX_CHANNELS
)
(
    input  logic            clk,
    input  logic            rst_n,
    icmn_pixel_if.sink      pixels,
    icmn_result_if.source   results,
    icmn_cfg_if.sink        cfg
);

    cfg_regs_t regs;
    logic      stage_valid;
    logic      stage_ready;
    stage_t    stage;

    // Hold the configuration registers
    icmn_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Track position, crop and mirror
    icmn_position #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .regs        (regs),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage       (stage)
    );

    // Scale and register the result
    icmn_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage_ready  (stage_ready),
        .stage        (stage),
        .scale_factor (regs.scale_factor),
        .results      (results)
    );

endmodule
